### hw/rtl/jvs_rx_pkg.sv
// ----------------------------------------------------------------------------
// JVS receiver package
// Shared constants and types for the response frame receiver.
// ----------------------------------------------------------------------------
package jvs_rx_pkg;

    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int USER_W     = 4;
    localparam int TDATA_W    = 2 * BYTE_W;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'hE0;
    localparam logic [BYTE_W-1:0] MARK_BYTE = 8'hD0;

    localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDRESS     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH = 1'b1;

    typedef enum logic [1:0] {
        PH_HUNT = 2'd0,
        PH_DEST = 2'd1,
        PH_LEN  = 2'd2,
        PH_DATA = 2'd3
    } phase_t;

    typedef struct packed {
        logic report_ok;
        logic status_ok;
        logic length_ok;
        logic checksum_ok;
    } flags_t;

endpackage

### hw/rtl/jvs_response_frame_receiver.sv
// ----------------------------------------------------------------------------
// JVS response frame receiver
// Hunts for sync, filters on destination, unescapes and checks one frame.
// ----------------------------------------------------------------------------
//  Channel   Direction  Content
//  s_*       in         one raw line byte per request
//  m_*       out        one payload byte with index and frame flags
//  cfg_*     in         own address and expected length writes
//
//  One line byte is taken per cycle while the m_ side does not stall; each request is decoded
//  into the result register, which feeds the m_ channel directly.
//  A result waiting on the m_ side stalls the s_ side only while m_tready
//  is low. Reset is synchronous and returns the receiver to sync hunting.
module jvs_response_frame_receiver (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [jvs_rx_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [jvs_rx_pkg::TDATA_W-1:0]   m_tdata,   // [7:0] payload_byte, [15:8] byte_index
    output logic                             m_tlast,   // is_last
    output logic [jvs_rx_pkg::USER_W-1:0]    m_tuser,   // checksum_ok, length_ok, status_ok, report_ok
    input  logic                             cfg_we,
    input  logic [jvs_rx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [jvs_rx_pkg::BYTE_W-1:0]    cfg_wdata
);
    import jvs_rx_pkg::*;

    phase_t              phase_reg, phase_next;
    logic                escape_reg, escape_next;
    logic [BYTE_W-1:0]   len_reg, len_next;
    logic [BYTE_W-1:0]   taken_reg, taken_next;
    logic [BYTE_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]   status_reg, status_next;
    logic [BYTE_W-1:0]   report_reg, report_next;
    logic [BYTE_W-1:0]   own_reg, exp_reg;

    logic                m_valid_reg;
    logic [BYTE_W-1:0]   m_byte_reg, m_index_reg;
    logic                m_last_reg;
    flags_t              m_flags_reg;

    logic                accept;
    logic [BYTE_W-1:0]   raw, value, idx_inc, st_cur, rp_cur;
    logic                mark_seen, len_bad, frame_end;
    logic                res_valid, res_last;
    logic [BYTE_W-1:0]   res_byte, res_index;
    flags_t              res_flags;

    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign raw       = s_tdata;
    assign value     = escape_reg ? raw + 8'd1 : raw;
    assign mark_seen = !escape_reg && (raw == MARK_BYTE);
    assign len_bad   = (value == '0) || ((exp_reg != '0) && (value != exp_reg));
    assign idx_inc   = taken_reg + 8'd1;
    assign frame_end = idx_inc >= len_reg;
    assign st_cur    = (taken_reg == 8'd0) ? value : status_reg;
    assign rp_cur    = (taken_reg == 8'd1) ? value : report_reg;

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_HUNT: begin
                if (raw == SYNC_BYTE) begin
                    phase_next = PH_DEST;
                end
            end
            PH_DEST: begin
                if (!mark_seen) begin
                    phase_next = (value == own_reg) ? PH_LEN : PH_HUNT;
                end
            end
            PH_LEN: begin
                if (!mark_seen) begin
                    phase_next = len_bad ? PH_HUNT : PH_DATA;
                end
            end
            PH_DATA: begin
                if (!mark_seen && frame_end) begin
                    phase_next = PH_HUNT;
                end
            end
            default: phase_next = PH_HUNT;
        endcase
    end

    always_comb begin
        escape_next = (phase_reg == PH_HUNT) ? 1'b0 : mark_seen;
        len_next    = len_reg;
        taken_next  = taken_reg;
        sum_next    = sum_reg;
        status_next = status_reg;
        report_next = report_reg;
        res_valid   = 1'b0;
        res_last    = 1'b0;
        res_byte    = '0;
        res_index   = '0;
        res_flags   = '0;
        if (phase_reg == PH_LEN && !mark_seen) begin
            if (len_bad) begin
                res_valid = 1'b1;
                res_last  = 1'b1;
            end else begin
                len_next    = value;
                taken_next  = '0;
                sum_next    = value;
                status_next = '0;
                report_next = '0;
            end
        end else if (phase_reg == PH_DATA && !mark_seen) begin
            status_next         = st_cur;
            report_next         = rp_cur;
            taken_next          = idx_inc;
            res_valid           = 1'b1;
            res_byte            = value;
            res_index           = taken_reg;
            res_flags.length_ok = 1'b1;
            if (frame_end) begin
                res_last              = 1'b1;
                res_flags.checksum_ok = (sum_reg == value);
                res_flags.status_ok   = (st_cur == 8'd1);
                res_flags.report_ok   = !(rp_cur inside {[8'd2:8'd4]});
            end else begin
                sum_next = sum_reg + value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_HUNT;
            escape_reg <= 1'b0;
            len_reg    <= '0;
            taken_reg  <= '0;
            sum_reg    <= '0;
            status_reg <= '0;
            report_reg <= '0;
        end else if (accept) begin
            phase_reg  <= phase_next;
            escape_reg <= escape_next;
            len_reg    <= len_next;
            taken_reg  <= taken_next;
            sum_reg    <= sum_next;
            status_reg <= status_next;
            report_reg <= report_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            own_reg <= '0;
            exp_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_OWN_ADDRESS:     own_reg <= cfg_wdata;
                CFG_EXPECTED_LENGTH: exp_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_tready) begin
            m_valid_reg <= accept && res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && res_valid) begin
            m_byte_reg  <= res_byte;
            m_index_reg <= res_index;
            m_last_reg  <= res_last;
            m_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_index_reg, m_byte_reg};
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_flags_reg;

`ifndef SYNTHESIS
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_abort_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_flags_reg.length_ok |-> m_tlast && (m_tdata == '0))
        else $error("aborted frame result malformed");

    a_flags_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_flags_reg.length_ok && !m_flags_reg.checksum_ok
            && !m_flags_reg.status_ok && !m_flags_reg.report_ok)
        else $error("frame flags set before the last byte");

    a_last_rehunts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && res_valid && res_last |=> phase_reg == PH_HUNT)
        else $error("receiver did not return to hunting after frame end");

    a_hunt_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HUNT || phase_reg == PH_DEST |-> !res_valid)
        else $error("result produced outside a frame");
`endif

endmodule
